@@ src/ple_pkg.sv @@
// ============================================================================
// ple_pkg
// Shared types and constants of the positional list engine: sizes, request
// and status codes, the controller states and the command sent to the cells.
// ============================================================================
package ple_pkg;

    localparam int CAPACITY = 64;
    localparam int WORD_W   = 32;
    localparam int POS_W    = $clog2(CAPACITY + 1);
    localparam int IN_POS_W = 8;
    localparam int CMP_W    = (POS_W > IN_POS_W) ? POS_W : IN_POS_W;
    localparam int TOTAL_W  = 7;
    localparam int REQ_W    = 3;
    localparam int STATUS_W = 2;
    localparam int GRP_SIZE = 8;
    localparam int NUM_GRP  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [POS_W-1:0]  t_pos;

    typedef enum logic [REQ_W-1:0] {
        REQ_READ      = 3'd0,
        REQ_INSERT_AT = 3'd1,
        REQ_INSERT_HD = 3'd2,
        REQ_INSERT_TL = 3'd3,
        REQ_DELETE    = 3'd4
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_REDUCE
    } t_state;

    typedef struct packed {
        logic  shift_up;
        logic  shift_down;
        t_pos  pos;
        t_word value;
    } t_cell_cmd;

endpackage

@@ src/ple_cell.sv @@
// ============================================================================
// ple_cell
// One list slot: holds an entry, takes its neighbour's entry on a shift and
// offers its entry to the read tree when the command addresses it.
// ============================================================================
module ple_cell (
    input  logic              i_clk,
    input  ple_pkg::t_pos      i_index,
    input  ple_pkg::t_cell_cmd i_cmd,
    input  ple_pkg::t_word     i_left,
    input  ple_pkg::t_word     i_right,
    output ple_pkg::t_word     o_entry,
    output ple_pkg::t_word     o_tap
);

    ple_pkg::t_word r_entry;
    ple_pkg::t_word n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.shift_up) begin
            if (i_index > i_cmd.pos) begin
                n_entry = i_left;
            end else if (i_index == i_cmd.pos) begin
                n_entry = i_cmd.value;
            end
        end else if (i_cmd.shift_down) begin
            if (i_index >= i_cmd.pos) begin
                n_entry = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_tap   = (i_index == i_cmd.pos) ? r_entry : '0;

endmodule

@@ src/ple_cell_row.sv @@
// ============================================================================
// ple_cell_row
// The row of list cells, each wired to its neighbours so that an insert
// shifts the tail up and a delete shifts it down.
// ============================================================================
module ple_cell_row (
    input  logic               i_clk,
    input  ple_pkg::t_cell_cmd i_cmd,
    output ple_pkg::t_word     o_taps [ple_pkg::CAPACITY]
);

    ple_pkg::t_word w_entry [ple_pkg::CAPACITY];

    for (genvar g = 0; g < ple_pkg::CAPACITY; g++) begin : g_cell
        ple_pkg::t_word w_left;
        ple_pkg::t_word w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_entry[g-1];
        end

        if (g == ple_pkg::CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_entry[g+1];
        end

        ple_cell u_cell (
            .i_clk   (i_clk),
            .i_index (ple_pkg::POS_W'(g)),
            .i_cmd   (i_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_entry[g]),
            .o_tap   (o_taps[g])
        );
    end

endmodule

@@ src/ple_read_tree.sv @@
// ============================================================================
// ple_read_tree
// Two-level OR tree that collects the one addressed cell's entry: groups of
// eight are combined into registers, then the group registers are combined.
// ============================================================================
module ple_read_tree (
    input  logic           i_clk,
    input  logic           i_load,
    input  ple_pkg::t_word i_taps [ple_pkg::CAPACITY],
    output ple_pkg::t_word o_value
);

    ple_pkg::t_word r_grp [ple_pkg::NUM_GRP];
    ple_pkg::t_word n_grp [ple_pkg::NUM_GRP];

    always_comb begin
        for (int g = 0; g < ple_pkg::NUM_GRP; g++) begin
            n_grp[g] = '0;
            for (int k = 0; k < ple_pkg::GRP_SIZE; k++) begin
                if (g * ple_pkg::GRP_SIZE + k < ple_pkg::CAPACITY) begin
                    n_grp[g] = n_grp[g] | i_taps[g * ple_pkg::GRP_SIZE + k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_grp <= n_grp;
        end
    end

    always_comb begin
        o_value = '0;
        for (int g = 0; g < ple_pkg::NUM_GRP; g++) begin
            o_value = o_value | r_grp[g];
        end
    end

endmodule

@@ src/positional_list_engine.sv @@
// ============================================================================
// positional_list_engine
// Ordered list of signed 32-bit values with read, positional insert and
// delete, held in a row of cells that shift all entries in parallel.
//
//   Channel   Handshake                   Payload
//   request   i_in_valid / o_in_ready     i_req_type, i_position, i_value
//   result    o_out_valid / i_out_ready   o_read_value, o_status, o_entry_total
//
// In a transaction, the cells update and the read tree's first level is
// captured at acceptance, and the second level is combined into the output
// register in the reduce state once that register is free. One request is in
// flight at a time, so no new request is accepted until the last is loaded.
// The output register holds a result until taken; a stalled result stalls the
// next request in its reduce state. Reset clears the list count and handshake.
// ============================================================================
module positional_list_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_req_type,
    input  logic signed [7:0]  i_position,
    input  logic signed [31:0] i_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic signed [31:0] o_read_value,
    output logic [1:0]  o_status,
    output logic [6:0]  o_entry_total
);

    ple_pkg::t_state    r_state;
    ple_pkg::t_state    n_state;
    ple_pkg::t_pos      r_count;
    ple_pkg::t_pos      n_count;
    ple_pkg::t_status   r_stat;
    ple_pkg::t_status   n_stat;
    logic               r_is_read;
    logic               n_is_read;
    logic               r_rd_ok;
    logic               n_rd_ok;
    logic               r_out_valid;
    ple_pkg::t_word     r_read_value;
    ple_pkg::t_status   r_status_out;
    logic [ple_pkg::TOTAL_W-1:0] r_total_out;

    logic               w_accept;
    logic               w_load_out;
    logic               w_pos_neg;
    logic [ple_pkg::CMP_W-1:0] w_pos_mag;
    logic [ple_pkg::CMP_W-1:0] w_count_ext;
    logic               w_full;
    ple_pkg::t_cell_cmd w_cmd;
    ple_pkg::t_word     w_taps [ple_pkg::CAPACITY];
    ple_pkg::t_word     w_tree_value;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ple_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = ple_pkg::S_REDUCE;
                end
            end
            ple_pkg::S_REDUCE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ple_pkg::S_IDLE;
                end
            end
            default: n_state = ple_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            ple_pkg::S_IDLE:   o_in_ready = 1'b1;
            ple_pkg::S_REDUCE: w_load_out = !r_out_valid || i_out_ready;
            default: begin
                o_in_ready = 1'b0;
                w_load_out = 1'b0;
            end
        endcase
    end

    assign w_accept    = i_in_valid && o_in_ready;
    assign w_pos_neg   = i_position[7];
    assign w_pos_mag   = ple_pkg::CMP_W'($unsigned(i_position));
    assign w_count_ext = ple_pkg::CMP_W'(r_count);
    assign w_full      = (r_count == ple_pkg::POS_W'(ple_pkg::CAPACITY));

    always_comb begin
        w_cmd            = '0;
        w_cmd.value      = i_value;
        w_cmd.pos        = w_pos_mag[ple_pkg::POS_W-1:0];
        n_count          = r_count;
        n_stat           = ple_pkg::STAT_DONE;
        n_is_read        = 1'b0;
        n_rd_ok          = 1'b0;
        unique case (i_req_type)
            ple_pkg::REQ_READ: begin
                n_is_read = 1'b1;
                n_rd_ok   = !w_pos_neg && (w_pos_mag < w_count_ext);
                n_stat    = n_rd_ok ? ple_pkg::STAT_DONE : ple_pkg::STAT_RANGE;
            end
            ple_pkg::REQ_INSERT_AT: begin
                if (w_pos_neg || (w_pos_mag > w_count_ext)) begin
                    n_stat = ple_pkg::STAT_RANGE;
                end else if (w_full) begin
                    n_stat = ple_pkg::STAT_FULL;
                end else begin
                    w_cmd.shift_up = w_accept;
                    n_count        = r_count + 1'b1;
                end
            end
            ple_pkg::REQ_INSERT_HD: begin
                w_cmd.pos = '0;
                if (w_full) begin
                    n_stat = ple_pkg::STAT_FULL;
                end else begin
                    w_cmd.shift_up = w_accept;
                    n_count        = r_count + 1'b1;
                end
            end
            ple_pkg::REQ_INSERT_TL: begin
                w_cmd.pos = r_count;
                if (w_full) begin
                    n_stat = ple_pkg::STAT_FULL;
                end else begin
                    w_cmd.shift_up = w_accept;
                    n_count        = r_count + 1'b1;
                end
            end
            ple_pkg::REQ_DELETE: begin
                if (w_pos_neg || (w_pos_mag >= w_count_ext)) begin
                    n_stat = ple_pkg::STAT_RANGE;
                end else begin
                    w_cmd.shift_down = w_accept;
                    n_count          = r_count - 1'b1;
                end
            end
            default: n_stat = ple_pkg::STAT_DONE;
        endcase
    end

    ple_cell_row u_row (
        .i_clk  (i_clk),
        .i_cmd  (w_cmd),
        .o_taps (w_taps)
    );

    ple_read_tree u_tree (
        .i_clk   (i_clk),
        .i_load  (w_accept),
        .i_taps  (w_taps),
        .o_value (w_tree_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ple_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_count <= n_count;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_stat    <= n_stat;
            r_is_read <= n_is_read;
            r_rd_ok   <= n_rd_ok;
        end
        if (w_load_out) begin
            r_status_out <= r_stat;
            r_total_out  <= ple_pkg::TOTAL_W'(r_count);
            if (!r_is_read) begin
                r_read_value <= '0;
            end else if (r_rd_ok) begin
                r_read_value <= w_tree_value;
            end else begin
                r_read_value <= '1;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_value  = r_read_value;
    assign o_status      = r_status_out;
    assign o_entry_total = r_total_out;

endmodule
